// ===== rtl/core/vtp_pkg.sv =====
// ----------------------------------------------------------------------------
// vtp_pkg: shared types and constants of the terminal escape parser
// Event codes, byte codes and the command record passed from front to back.
// ----------------------------------------------------------------------------
package vtp_pkg;

   // event kinds on the result channel
   localparam logic [2:0] EV_EXEC  = 3'd0;
   localparam logic [2:0] EV_PRINT = 3'd1;
   localparam logic [2:0] EV_ESC   = 3'd2;
   localparam logic [2:0] EV_CSI   = 3'd3;
   localparam logic [2:0] EV_OSC   = 3'd4;

   // byte codes
   localparam logic [7:0] B_BEL    = 8'h07;
   localparam logic [7:0] B_CAN    = 8'h18;
   localparam logic [7:0] B_SUB    = 8'h1A;
   localparam logic [7:0] B_ESC    = 8'h1B;
   localparam logic [7:0] B_SPACE  = 8'h20;
   localparam logic [7:0] B_INTMAX = 8'h2F;
   localparam logic [7:0] B_ZERO   = 8'h30;
   localparam logic [7:0] B_NINE   = 8'h39;
   localparam logic [7:0] B_COLON  = 8'h3A;
   localparam logic [7:0] B_SEMI   = 8'h3B;
   localparam logic [7:0] B_PRVLO  = 8'h3C;
   localparam logic [7:0] B_PRVHI  = 8'h3F;
   localparam logic [7:0] B_FINLO  = 8'h40;
   localparam logic [7:0] B_CSI    = 8'h5B;
   localparam logic [7:0] B_OSC    = 8'h5D;
   localparam logic [7:0] B_FINHI  = 8'h7E;
   localparam logic [7:0] B_DEL    = 8'h7F;
   localparam logic [7:0] B_HIGH   = 8'h80;

   // largest parameter that may still take a digit
   localparam logic [19:0] PARAM_LIMIT = 20'd99999;

   // one queued event: simple events carry item_count zero
   typedef struct packed {
      logic [2:0]  kind;
      logic [20:0] code;
      logic        priv;
      logic [1:0]  icnt;
      logic [7:0]  i1;
      logic [7:0]  i2;
      logic [6:0]  count;
      logic [19:0] tail;
   } cmd_type;

endpackage

// ===== rtl/core/vtp_ram.sv =====
// ----------------------------------------------------------------------------
// vtp_ram: generic single write, single read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module vtp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write, and read on request
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/vtp_queue.sv =====
// ----------------------------------------------------------------------------
// vtp_queue: two-entry command queue
// Decouples the byte classifier from the result sequencer.
// ----------------------------------------------------------------------------
module vtp_queue
   import vtp_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   input  logic    pop,
   output logic    full,
   output logic    avail,
   output cmd_type head
);

   cmd_type    slot_ff [2];
   logic       wp_ff, wp_in;
   logic       rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;

   assign full  = (cnt_ff == 2'd2);
   assign avail = (cnt_ff != 2'd0);
   assign head  = slot_ff[rp_ff];

   // advance pointers and count
   always_comb begin
      wp_in  = push ? ~wp_ff : wp_ff;
      rp_in  = pop ? ~rp_ff : rp_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   // hold entries
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wp_ff] <= push_cmd;
      end
   end

endmodule

// ===== rtl/core/vtp_front.sv =====
// ----------------------------------------------------------------------------
// vtp_front: byte classifier and sequence collector
// Runs the escape/CSI/OSC state machine and UTF-8 decoder, fills the stores
// and queues one command per event.
// ----------------------------------------------------------------------------
module vtp_front
   import vtp_pkg::*;
#(
   parameter int MAX_PARAMS        = 16,
   parameter int MAX_INTERMEDIATES = 2,
   parameter int OSC_MAX_LEN       = 64,
   localparam int PCW = $clog2(MAX_PARAMS + 1),
   localparam int PAW = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1,
   localparam int OLW = $clog2(OSC_MAX_LEN + 1),
   localparam int OAW = (OSC_MAX_LEN > 1) ? $clog2(OSC_MAX_LEN) : 1
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            accept,
   input  logic [7:0]      in_byte,
   input  logic            run_done,
   output logic            busy,
   output logic            push,
   output cmd_type         push_cmd,
   output logic            par_we,
   output logic [PAW-1:0]  par_wa,
   output logic [19:0]     par_wd,
   output logic            osc_we,
   output logic [OAW-1:0]  osc_wa,
   output logic [7:0]      osc_wd
);

   localparam logic [2:0] PH_GROUND    = 3'd0;
   localparam logic [2:0] PH_ESC       = 3'd1;
   localparam logic [2:0] PH_ESC_INTER = 3'd2;
   localparam logic [2:0] PH_CSI_ENTRY = 3'd3;
   localparam logic [2:0] PH_CSI_PARAM = 3'd4;
   localparam logic [2:0] PH_CSI_INTER = 3'd5;
   localparam logic [2:0] PH_CSI_IGN   = 3'd6;
   localparam logic [2:0] PH_OSC       = 3'd7;

   localparam logic [PCW-1:0] MAXP = PCW'(MAX_PARAMS);
   localparam logic [OLW-1:0] MAXO = OLW'(OSC_MAX_LEN);
   localparam logic [1:0]     MAXI = 2'(MAX_INTERMEDIATES);

   logic [2:0]     phase_ff, phase_in;
   logic [20:0]    acc_ff, acc_in;
   logic [1:0]     rem_ff, rem_in;
   logic [PCW-1:0] pcnt_ff, pcnt_in;
   logic [19:0]    cur_ff, cur_in;
   logic           priv_ff, priv_in;
   logic           ovf_ff, ovf_in;
   logic [7:0]     ci0_ff, ci0_in, ci1_ff, ci1_in;
   logic [1:0]     ccnt_ff, ccnt_in;
   logic [7:0]     ei0_ff, ei0_in, ei1_ff, ei1_in;
   logic [1:0]     ecnt_ff, ecnt_in;
   logic [OLW-1:0] olen_ff, olen_in;
   logic           oovf_ff, oovf_in;
   logic           busy_ff, busy_in;

   logic           is_inter, is_cfinal, is_efinal, is_c0, is_digit, is_sep, is_cont;
   logic [PCW-1:0] effc;
   logic [19:0]    effv;
   logic [20:0]    acc_next;

   assign busy = busy_ff;

   // classify the byte
   always_comb begin
      is_inter  = (in_byte >= B_SPACE) && (in_byte <= B_INTMAX);
      is_cfinal = (in_byte >= B_FINLO) && (in_byte <= B_FINHI);
      is_efinal = (in_byte >= B_ZERO) && (in_byte <= B_FINHI);
      is_c0     = (in_byte < B_SPACE);
      is_digit  = (in_byte >= B_ZERO) && (in_byte <= B_NINE);
      is_sep    = (in_byte == B_SEMI) || (in_byte == B_COLON);
      is_cont   = (in_byte[7:6] == 2'b10);
      acc_next  = {acc_ff[14:0], in_byte[5:0]};
      effc      = (pcnt_ff == '0) ? PCW'(1) : pcnt_ff;
      effv      = (pcnt_ff == '0) ? 20'd0 : cur_ff;
   end

   // next state of the parser
   always_comb begin
      phase_in = phase_ff;
      acc_in   = acc_ff;
      rem_in   = rem_ff;
      pcnt_in  = pcnt_ff;
      cur_in   = cur_ff;
      priv_in  = priv_ff;
      ovf_in   = ovf_ff;
      ci0_in   = ci0_ff;
      ci1_in   = ci1_ff;
      ccnt_in  = ccnt_ff;
      ei0_in   = ei0_ff;
      ei1_in   = ei1_ff;
      ecnt_in  = ecnt_ff;
      olen_in  = olen_ff;
      oovf_in  = oovf_ff;
      busy_in  = busy_ff && !run_done;
      push     = 1'b0;
      push_cmd = '0;
      par_we   = 1'b0;
      par_wa   = '0;
      par_wd   = '0;
      osc_we   = 1'b0;
      osc_wa   = olen_ff[OAW-1:0];
      osc_wd   = in_byte;

      if (accept) begin
         if (in_byte == B_CAN || in_byte == B_SUB) begin
            phase_in = PH_GROUND;
         end else begin
            unique case (phase_ff)
               PH_GROUND: begin
                  if (in_byte == B_ESC) begin
                     phase_in = PH_ESC;
                     ecnt_in  = 2'd0;
                  end else if (in_byte == B_DEL) begin
                     phase_in = PH_GROUND;
                  end else if (is_c0) begin
                     push          = 1'b1;
                     push_cmd.kind = EV_EXEC;
                     push_cmd.code = {13'd0, in_byte};
                  end else if (rem_ff != 2'd0 && is_cont) begin
                     // continue a multi-byte character
                     rem_in = rem_ff - 2'd1;
                     acc_in = acc_next;
                     if (rem_ff == 2'd1) begin
                        acc_in        = '0;
                        push          = 1'b1;
                        push_cmd.kind = EV_PRINT;
                        push_cmd.code = acc_next;
                     end
                  end else begin
                     // fresh byte: a broken sequence restarts here
                     acc_in = '0;
                     rem_in = 2'd0;
                     if (in_byte < B_HIGH) begin
                        push          = 1'b1;
                        push_cmd.kind = EV_PRINT;
                        push_cmd.code = {13'd0, in_byte};
                     end else if (in_byte[7:5] == 3'b110) begin
                        acc_in = {16'd0, in_byte[4:0]};
                        rem_in = 2'd1;
                     end else if (in_byte[7:4] == 4'b1110) begin
                        acc_in = {17'd0, in_byte[3:0]};
                        rem_in = 2'd2;
                     end else if (in_byte[7:3] == 5'b11110) begin
                        acc_in = {18'd0, in_byte[2:0]};
                        rem_in = 2'd3;
                     end
                  end
               end
               PH_ESC, PH_ESC_INTER: begin
                  if (phase_ff == PH_ESC && in_byte == B_CSI) begin
                     phase_in = PH_CSI_ENTRY;
                     pcnt_in  = '0;
                     priv_in  = 1'b0;
                     ovf_in   = 1'b0;
                     ccnt_in  = 2'd0;
                  end else if (phase_ff == PH_ESC && in_byte == B_OSC) begin
                     phase_in = PH_OSC;
                     olen_in  = '0;
                     oovf_in  = 1'b0;
                  end else if (is_inter) begin
                     phase_in = PH_ESC_INTER;
                     if (ecnt_ff < MAXI) begin
                        if (ecnt_ff == 2'd0) ei0_in = in_byte;
                        else ei1_in = in_byte;
                        ecnt_in = ecnt_ff + 2'd1;
                     end
                  end else if (is_efinal) begin
                     phase_in      = PH_GROUND;
                     push          = 1'b1;
                     push_cmd.kind = EV_ESC;
                     push_cmd.code = {13'd0, in_byte};
                     push_cmd.icnt = ecnt_ff;
                     push_cmd.i1   = (ecnt_ff > 2'd0) ? ei0_ff : 8'd0;
                     push_cmd.i2   = (ecnt_ff > 2'd1) ? ei1_ff : 8'd0;
                  end else if (is_c0) begin
                     push          = 1'b1;
                     push_cmd.kind = EV_EXEC;
                     push_cmd.code = {13'd0, in_byte};
                  end else begin
                     phase_in = PH_GROUND;
                  end
               end
               PH_CSI_ENTRY, PH_CSI_PARAM, PH_CSI_INTER, PH_CSI_IGN: begin
                  if (is_c0) begin
                     push          = 1'b1;
                     push_cmd.kind = EV_EXEC;
                     push_cmd.code = {13'd0, in_byte};
                  end else if (phase_ff == PH_CSI_IGN) begin
                     if (is_cfinal) phase_in = PH_GROUND;
                  end else if (phase_ff != PH_CSI_INTER && is_digit) begin
                     // accumulate the open parameter in a register
                     phase_in = PH_CSI_PARAM;
                     pcnt_in  = effc;
                     cur_in   = effv;
                     if (effv > PARAM_LIMIT) begin
                        ovf_in = 1'b1;
                     end else begin
                        cur_in = (effv << 3) + (effv << 1) + {16'd0, in_byte[3:0]};
                     end
                  end else if (phase_ff != PH_CSI_INTER && is_sep) begin
                     // close the open parameter into the store
                     phase_in = PH_CSI_PARAM;
                     pcnt_in  = effc;
                     cur_in   = effv;
                     if (effc < MAXP) begin
                        par_we  = 1'b1;
                        par_wa  = PAW'(effc - PCW'(1));
                        par_wd  = effv;
                        pcnt_in = effc + PCW'(1);
                        cur_in  = 20'd0;
                     end else begin
                        ovf_in = 1'b1;
                     end
                  end else if (phase_ff == PH_CSI_ENTRY && in_byte >= B_PRVLO
                               && in_byte <= B_PRVHI) begin
                     priv_in  = 1'b1;
                     phase_in = PH_CSI_PARAM;
                  end else if (is_inter) begin
                     phase_in = PH_CSI_INTER;
                     if (ccnt_ff < MAXI) begin
                        if (ccnt_ff == 2'd0) ci0_in = in_byte;
                        else ci1_in = in_byte;
                        ccnt_in = ccnt_ff + 2'd1;
                     end
                  end else if (is_cfinal) begin
                     phase_in = PH_GROUND;
                     if (!ovf_ff) begin
                        push           = 1'b1;
                        push_cmd.kind  = EV_CSI;
                        push_cmd.code  = {13'd0, in_byte};
                        push_cmd.priv  = priv_ff;
                        push_cmd.icnt  = ccnt_ff;
                        push_cmd.i1    = (ccnt_ff > 2'd0) ? ci0_ff : 8'd0;
                        push_cmd.i2    = (ccnt_ff > 2'd1) ? ci1_ff : 8'd0;
                        push_cmd.count = 7'(pcnt_ff);
                        push_cmd.tail  = cur_ff;
                        busy_in        = (pcnt_ff != '0);
                     end
                  end else begin
                     phase_in = PH_CSI_IGN;
                  end
               end
               PH_OSC: begin
                  if (in_byte == B_BEL || in_byte == B_ESC) begin
                     phase_in = PH_GROUND;
                     if (in_byte == B_ESC) begin
                        phase_in = PH_ESC;
                        ecnt_in  = 2'd0;
                     end
                     if (!oovf_ff) begin
                        push           = 1'b1;
                        push_cmd.kind  = EV_OSC;
                        push_cmd.count = 7'(olen_ff);
                        busy_in        = (olen_ff != '0);
                     end
                  end else if (olen_ff < MAXO) begin
                     osc_we  = 1'b1;
                     olen_in = olen_ff + OLW'(1);
                  end else begin
                     oovf_in = 1'b1;
                  end
               end
               default: phase_in = PH_GROUND;
            endcase
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_GROUND;
         acc_ff   <= '0;
         rem_ff   <= 2'd0;
         pcnt_ff  <= '0;
         priv_ff  <= 1'b0;
         ovf_ff   <= 1'b0;
         ccnt_ff  <= 2'd0;
         ecnt_ff  <= 2'd0;
         olen_ff  <= '0;
         oovf_ff  <= 1'b0;
         busy_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         acc_ff   <= acc_in;
         rem_ff   <= rem_in;
         pcnt_ff  <= pcnt_in;
         priv_ff  <= priv_in;
         ovf_ff   <= ovf_in;
         ccnt_ff  <= ccnt_in;
         ecnt_ff  <= ecnt_in;
         olen_ff  <= olen_in;
         oovf_ff  <= oovf_in;
         busy_ff  <= busy_in;
      end
   end

   // payload state
   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      ci0_ff <= ci0_in;
      ci1_ff <= ci1_in;
      ei0_ff <= ei0_in;
      ei1_ff <= ei1_in;
   end

endmodule

// ===== rtl/core/vtp_back.sv =====
// ----------------------------------------------------------------------------
// vtp_back: result sequencer
// Pops commands, walks CSI parameter and OSC byte runs through the stores
// and drives the registered result channel.
// ----------------------------------------------------------------------------
module vtp_back
   import vtp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        q_avail,
   input  cmd_type     q_head,
   output logic        q_pop,
   output logic        rd_en,
   output logic [5:0]  rd_addr,
   input  logic [19:0] par_rd,
   input  logic [7:0]  osc_rd,
   output logic        run_done,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_event_kind,
   output logic [20:0] rsp_code,
   output logic        rsp_private_flag,
   output logic [1:0]  rsp_inter_count,
   output logic [7:0]  rsp_inter_first,
   output logic [7:0]  rsp_inter_second,
   output logic [6:0]  rsp_item_count,
   output logic [5:0]  rsp_item_index,
   output logic [19:0] rsp_item_value,
   output logic        rsp_last
);

   localparam logic B_IDLE = 1'b0;
   localparam logic B_RUN  = 1'b1;

   logic        st_ff, st_in;
   cmd_type     run_ff, run_in;
   logic [5:0]  k_ff, k_in;
   logic        ov_ff, ov_in;
   logic [2:0]  kind_ff, kind_in;
   logic [20:0] code_ff, code_in;
   logic        priv_ff, priv_in;
   logic [1:0]  ic_ff, ic_in;
   logic [7:0]  i1_ff, i1_in, i2_ff, i2_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic [5:0]  idx_ff, idx_in;
   logic [19:0] val_ff, val_in;
   logic        last_ff, last_in;
   logic        out_free, is_final;
   logic [19:0] run_val;

   assign out_free = !ov_ff || !rsp_stall;

   // pick the value of the current run position
   always_comb begin
      is_final = ({1'b0, k_ff} + 7'd1 == run_ff.count);
      if (run_ff.kind == EV_CSI) begin
         run_val = is_final ? run_ff.tail : par_rd;
      end else begin
         run_val = {12'd0, osc_rd};
      end
   end

   // sequence results
   always_comb begin
      st_in    = st_ff;
      run_in   = run_ff;
      k_in     = k_ff;
      ov_in    = ov_ff && rsp_stall;
      kind_in  = kind_ff;
      code_in  = code_ff;
      priv_in  = priv_ff;
      ic_in    = ic_ff;
      i1_in    = i1_ff;
      i2_in    = i2_ff;
      cnt_in   = cnt_ff;
      idx_in   = idx_ff;
      val_in   = val_ff;
      last_in  = last_ff;
      q_pop    = 1'b0;
      rd_en    = 1'b0;
      rd_addr  = 6'd0;
      run_done = 1'b0;

      unique case (st_ff)
         B_IDLE: begin
            if (q_avail && out_free) begin
               q_pop = 1'b1;
               if (q_head.count == 7'd0) begin
                  ov_in   = 1'b1;
                  kind_in = q_head.kind;
                  code_in = q_head.code;
                  priv_in = q_head.priv;
                  ic_in   = q_head.icnt;
                  i1_in   = q_head.i1;
                  i2_in   = q_head.i2;
                  cnt_in  = 7'd0;
                  idx_in  = 6'd0;
                  val_in  = 20'd0;
                  last_in = 1'b1;
               end else begin
                  // open a run and fetch its first entry
                  st_in  = B_RUN;
                  run_in = q_head;
                  k_in   = 6'd0;
                  rd_en  = 1'b1;
               end
            end
         end
         B_RUN: begin
            if (out_free) begin
               ov_in   = 1'b1;
               kind_in = run_ff.kind;
               code_in = run_ff.code;
               priv_in = run_ff.priv;
               ic_in   = run_ff.icnt;
               i1_in   = run_ff.i1;
               i2_in   = run_ff.i2;
               cnt_in  = run_ff.count;
               idx_in  = k_ff;
               val_in  = run_val;
               last_in = is_final;
               if (is_final) begin
                  st_in    = B_IDLE;
                  run_done = 1'b1;
               end else begin
                  k_in    = k_ff + 6'd1;
                  rd_en   = 1'b1;
                  rd_addr = k_ff + 6'd1;
               end
            end
         end
         default: st_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= B_IDLE;
         ov_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         ov_ff <= ov_in;
      end
   end

   always_ff @(posedge clock) begin
      run_ff  <= run_in;
      k_ff    <= k_in;
      kind_ff <= kind_in;
      code_ff <= code_in;
      priv_ff <= priv_in;
      ic_ff   <= ic_in;
      i1_ff   <= i1_in;
      i2_ff   <= i2_in;
      cnt_ff  <= cnt_in;
      idx_ff  <= idx_in;
      val_ff  <= val_in;
      last_ff <= last_in;
   end

   assign rsp_valid        = ov_ff;
   assign rsp_event_kind   = kind_ff;
   assign rsp_code         = code_ff;
   assign rsp_private_flag = priv_ff;
   assign rsp_inter_count  = ic_ff;
   assign rsp_inter_first  = i1_ff;
   assign rsp_inter_second = i2_ff;
   assign rsp_item_count   = cnt_ff;
   assign rsp_item_index   = idx_ff;
   assign rsp_item_value   = val_ff;
   assign rsp_last         = last_ff;

endmodule

// ===== rtl/core/vt_escape_sequence_parser.sv =====
// A simple event goes through the command queue into the output register.
// Throughput: one byte per cycle while req_stall is low; a CSI or OSC run gives
// one result per cycle while rsp_stall is low, the first after its store read.
// Input stalls from a run's dispatch byte until its last result is loaded
// into the output register, and while the command queue is full.
// Reset: synchronous, active high; parser to ground, queue and output empty.
// ----------------------------------------------------------------------------
// vt_escape_sequence_parser: VT terminal byte parser with UTF-8 decoding
// Front classifier, two-entry command queue, result sequencer and stores.
// ----------------------------------------------------------------------------
module vt_escape_sequence_parser
   import vtp_pkg::*;
#(
   parameter int MAX_PARAMS        = 16,
   parameter int MAX_INTERMEDIATES = 2,
   parameter int OSC_MAX_LEN       = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_in_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_event_kind,
   output logic [20:0] rsp_code,
   output logic        rsp_private_flag,
   output logic [1:0]  rsp_inter_count,
   output logic [7:0]  rsp_inter_first,
   output logic [7:0]  rsp_inter_second,
   output logic [6:0]  rsp_item_count,
   output logic [5:0]  rsp_item_index,
   output logic [19:0] rsp_item_value,
   output logic        rsp_last
);

   localparam int PAW = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;
   localparam int OAW = (OSC_MAX_LEN > 1) ? $clog2(OSC_MAX_LEN) : 1;

   logic           accept, busy, run_done;
   logic           q_push, q_pop, q_full, q_avail;
   cmd_type        q_in, q_head;
   logic           par_we, osc_we, rd_en;
   logic [PAW-1:0] par_wa;
   logic [OAW-1:0] osc_wa;
   logic [19:0]    par_wd, par_rd;
   logic [7:0]     osc_wd, osc_rd;
   logic [5:0]     rd_addr;

   assign req_stall = busy || q_full;
   assign accept    = req_valid && !req_stall;

   vtp_front #(
      .MAX_PARAMS        (MAX_PARAMS),
      .MAX_INTERMEDIATES (MAX_INTERMEDIATES),
      .OSC_MAX_LEN       (OSC_MAX_LEN)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .in_byte  (req_in_byte),
      .run_done (run_done),
      .busy     (busy),
      .push     (q_push),
      .push_cmd (q_in),
      .par_we   (par_we),
      .par_wa   (par_wa),
      .par_wd   (par_wd),
      .osc_we   (osc_we),
      .osc_wa   (osc_wa),
      .osc_wd   (osc_wd)
   );

   vtp_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (q_in),
      .pop      (q_pop),
      .full     (q_full),
      .avail    (q_avail),
      .head     (q_head)
   );

   vtp_ram #(.WIDTH(20), .DEPTH(MAX_PARAMS)) u_par_ram (
      .clock   (clock),
      .wr_en   (par_we),
      .wr_addr (par_wa),
      .wr_data (par_wd),
      .rd_en   (rd_en),
      .rd_addr (rd_addr[PAW-1:0]),
      .rd_data (par_rd)
   );

   vtp_ram #(.WIDTH(8), .DEPTH(OSC_MAX_LEN)) u_osc_ram (
      .clock   (clock),
      .wr_en   (osc_we),
      .wr_addr (osc_wa),
      .wr_data (osc_wd),
      .rd_en   (rd_en),
      .rd_addr (rd_addr[OAW-1:0]),
      .rd_data (osc_rd)
   );

   vtp_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_avail          (q_avail),
      .q_head           (q_head),
      .q_pop            (q_pop),
      .rd_en            (rd_en),
      .rd_addr          (rd_addr),
      .par_rd           (par_rd),
      .osc_rd           (osc_rd),
      .run_done         (run_done),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_event_kind   (rsp_event_kind),
      .rsp_code         (rsp_code),
      .rsp_private_flag (rsp_private_flag),
      .rsp_inter_count  (rsp_inter_count),
      .rsp_inter_first  (rsp_inter_first),
      .rsp_inter_second (rsp_inter_second),
      .rsp_item_count   (rsp_item_count),
      .rsp_item_index   (rsp_item_index),
      .rsp_item_value   (rsp_item_value),
      .rsp_last         (rsp_last)
   );

`ifndef SYNTHESIS
   // a run keeps the output occupied until its last item
   a_run_cont: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |=> rsp_valid)
      else $error("run broke before its last item");

   // only CSI and OSC items come in runs
   a_run_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> rsp_event_kind == EV_CSI || rsp_event_kind == EV_OSC)
      else $error("multi-item run of a simple event");

   // the queue takes a command while full only in a cycle in which it also pops one
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full || q_pop)
      else $error("command queue overrun");
`endif

endmodule

// ===== tb/sv/vt_escape_sequence_parser_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// vt_escape_sequence_parser_tb: self-checking bench of the terminal parser
// Feeds directed and random byte streams (escape, CSI, OSC, UTF-8 and noise),
// predicts every event in a scoreboard and checks results in arrival order.
// ----------------------------------------------------------------------------
module vt_escape_sequence_parser_tb;
   import vtp_pkg::*;

   localparam int NUM_PARAMS = 16;
   localparam int NUM_INTER  = 2;
   localparam int OSC_LEN    = 64;

   // parser phases of the predictor
   typedef enum logic [2:0] {
      P_GROUND, P_ESC, P_ESC_INTER, P_CSI_ENTRY, P_CSI_PARAM, P_CSI_INTER,
      P_CSI_IGNORE, P_OSC
   } phase_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [20:0] code;
      logic        priv;
      logic [1:0]  icnt;
      logic [7:0]  i1;
      logic [7:0]  i2;
      logic [6:0]  count;
      logic [5:0]  index;
      logic [19:0] value;
      logic        last;
   } event_type;

   // scoreboard: parser predictor plus queue of expected events
   class event_scoreboard;
      event_type  pending[$];
      int         errors;
      phase_type  ph;
      logic [20:0] u_acc;
      int         u_rem;
      int         n_par;
      logic [19:0] par[NUM_PARAMS];
      logic       c_priv, c_ovf;
      logic [7:0] c_int[2];
      int         c_icnt;
      logic [7:0] e_int[2];
      int         e_icnt;
      logic [7:0] osc[OSC_LEN];
      int         o_len;
      logic       o_ovf;

      function new();
         ph = P_GROUND; u_acc = '0; u_rem = 0; n_par = 0;
         c_priv = 0; c_ovf = 0; c_icnt = 0; e_icnt = 0; o_len = 0; o_ovf = 0;
         errors = 0;
      endfunction

      function void push(logic [2:0] k, logic [20:0] c, logic p, int ic, logic [7:0] a,
                         logic [7:0] b, int cnt, int idx, logic [19:0] v, logic l);
         event_type e;
         e = '{k, c, p, ic[1:0], a, b, cnt[6:0], idx[5:0], v, l};
         pending.push_back(e);
      endfunction

      function void simple(logic [2:0] k, logic [20:0] c);
         push(k, c, 0, 0, 0, 0, 0, 0, 0, 1);
      endfunction

      function void osc_close();
         ph = P_GROUND;
         if (o_ovf) return;
         if (o_len == 0) push(EV_OSC, 0, 0, 0, 0, 0, 0, 0, 0, 1);
         for (int k = 0; k < o_len; k++)
            push(EV_OSC, 0, 0, 0, 0, 0, o_len, k, {12'd0, osc[k]}, k + 1 == o_len);
      endfunction

      function void csi_close(logic [7:0] b);
         logic [7:0] a1, a2;
         ph = P_GROUND;
         if (c_ovf) return;
         a1 = c_icnt > 0 ? c_int[0] : 8'd0;
         a2 = c_icnt > 1 ? c_int[1] : 8'd0;
         if (n_par == 0) push(EV_CSI, {13'd0, b}, c_priv, c_icnt, a1, a2, 0, 0, 0, 1);
         for (int k = 0; k < n_par; k++)
            push(EV_CSI, {13'd0, b}, c_priv, c_icnt, a1, a2, n_par, k, par[k],
                 k + 1 == n_par);
      endfunction

      function void ground(logic [7:0] b);
         if (b == B_ESC) begin ph = P_ESC; e_icnt = 0; return; end
         if (b == B_DEL) return;
         if (b < B_SPACE) begin simple(EV_EXEC, {13'd0, b}); return; end
         if (u_rem > 0) begin
            if (b[7:6] != 2'b10) begin
               u_rem = 0; u_acc = 0;
            end else begin
               u_acc = {u_acc[14:0], b[5:0]};
               u_rem--;
               if (u_rem == 0) begin simple(EV_PRINT, u_acc); u_acc = 0; end
               return;
            end
         end
         if (b < B_HIGH) simple(EV_PRINT, {13'd0, b});
         else if (b[7:5] == 3'b110) begin u_acc = {16'd0, b[4:0]}; u_rem = 1; end
         else if (b[7:4] == 4'b1110) begin u_acc = {17'd0, b[3:0]}; u_rem = 2; end
         else if (b[7:3] == 5'b11110) begin u_acc = {18'd0, b[2:0]}; u_rem = 3; end
         else begin u_acc = 0; u_rem = 0; end
      endfunction

      // note an accepted input byte and predict its events
      function void note_byte(logic [7:0] b);
         logic is_int, cfin, efin;
         is_int = b >= B_SPACE && b <= B_INTMAX;
         cfin = b >= B_FINLO && b <= B_FINHI;
         efin = b >= B_ZERO && b <= B_FINHI;
         if (b == B_CAN || b == B_SUB) begin ph = P_GROUND; return; end
         case (ph)
            P_GROUND: ground(b);
            P_ESC, P_ESC_INTER: begin
               if (ph == P_ESC && b == B_CSI) begin
                  ph = P_CSI_ENTRY; n_par = 0; c_priv = 0; c_ovf = 0; c_icnt = 0;
               end else if (ph == P_ESC && b == B_OSC) begin
                  ph = P_OSC; o_len = 0; o_ovf = 0;
               end else if (is_int) begin
                  if (e_icnt < NUM_INTER) begin e_int[e_icnt] = b; e_icnt++; end
                  ph = P_ESC_INTER;
               end else if (efin) begin
                  push(EV_ESC, {13'd0, b}, 0, e_icnt, e_icnt > 0 ? e_int[0] : 8'd0,
                       e_icnt > 1 ? e_int[1] : 8'd0, 0, 0, 0, 1);
                  ph = P_GROUND;
               end else if (b < B_SPACE) simple(EV_EXEC, {13'd0, b});
               else ph = P_GROUND;
            end
            P_CSI_ENTRY, P_CSI_PARAM: begin
               if (b < B_SPACE) simple(EV_EXEC, {13'd0, b});
               else if (b >= B_ZERO && b <= B_NINE) begin
                  if (n_par == 0) begin n_par = 1; par[0] = 0; end
                  if (n_par > NUM_PARAMS || par[n_par-1] > PARAM_LIMIT) c_ovf = 1;
                  else par[n_par-1] = 20'(par[n_par-1] * 10 + (b - B_ZERO));
                  ph = P_CSI_PARAM;
               end else if (b == B_SEMI || b == B_COLON) begin
                  if (n_par == 0) begin n_par = 1; par[0] = 0; end
                  if (n_par < NUM_PARAMS) begin par[n_par] = 0; n_par++; end
                  else c_ovf = 1;
                  ph = P_CSI_PARAM;
               end else if (ph == P_CSI_ENTRY && b >= B_PRVLO && b <= B_PRVHI) begin
                  c_priv = 1; ph = P_CSI_PARAM;
               end else if (is_int) begin
                  if (c_icnt < NUM_INTER) begin c_int[c_icnt] = b; c_icnt++; end
                  ph = P_CSI_INTER;
               end else if (cfin) csi_close(b);
               else ph = P_CSI_IGNORE;
            end
            P_CSI_INTER: begin
               if (b < B_SPACE) simple(EV_EXEC, {13'd0, b});
               else if (is_int) begin
                  if (c_icnt < NUM_INTER) begin c_int[c_icnt] = b; c_icnt++; end
               end else if (cfin) csi_close(b);
               else ph = P_CSI_IGNORE;
            end
            P_CSI_IGNORE: begin
               if (b < B_SPACE) simple(EV_EXEC, {13'd0, b});
               else if (cfin) ph = P_GROUND;
            end
            default: begin
               if (b == B_BEL) osc_close();
               else if (b == B_ESC) begin osc_close(); ph = P_ESC; e_icnt = 0; end
               else if (o_len < OSC_LEN) begin osc[o_len] = b; o_len++; end
               else o_ovf = 1;
            end
         endcase
      endfunction

      // compare one result against the oldest expected event
      function void check_event(event_type got);
         event_type want;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result %p", $realtime, got);
            errors++;
            return;
         end
         want = pending.pop_front();
         if (got !== want) begin
            $display("%0t: mismatch expected %p actual %p", $realtime, want, got);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_stall;
   logic [7:0]  req_in_byte = 0;
   logic        rsp_valid;
   logic        rsp_stall = 0;
   logic [2:0]  rsp_event_kind;
   logic [20:0] rsp_code;
   logic        rsp_private_flag;
   logic [1:0]  rsp_inter_count;
   logic [7:0]  rsp_inter_first, rsp_inter_second;
   logic [6:0]  rsp_item_count;
   logic [5:0]  rsp_item_index;
   logic [19:0] rsp_item_value;
   logic        rsp_last;

   event_scoreboard sb = new();
   logic [7:0] byte_queue[$];
   int         hold_off = 0;
   logic       quiet_rx = 0;

   vt_escape_sequence_parser dut (.*);

   always #4 clock = ~clock;

   // short gaps mostly, occasionally long
   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // send one byte, holding it until accepted; returns at a falling edge
   task automatic send_byte(logic [7:0] b);
      int g;
      g = gap_len();
      if (g > 0) begin
         req_valid <= 0;
         repeat (g) @(negedge clock);
      end
      req_in_byte <= b;
      req_valid <= 1;
      do @(posedge clock); while (req_stall);
      sb.note_byte(b);
      @(negedge clock);
   endtask

   // drain the byte queue, then drop valid
   task automatic send_all();
      while (byte_queue.size() > 0) send_byte(byte_queue.pop_front());
      req_valid <= 0;
   endtask

   task automatic wait_drained();
      while (sb.pending.size() > 0) @(negedge clock);
   endtask

   task automatic add_str(string s);
      for (int k = 0; k < s.len(); k++) byte_queue.push_back(s[k]);
   endtask

   // random well-formed sequences with random content, plus noise
   task automatic add_random_sequence();
      int sel, n;
      sel = $urandom_range(0, 9);
      case (sel)
         0, 1, 2: begin
            add_str("\033[");
            if ($urandom_range(0, 3) == 0)
               byte_queue.push_back(8'($urandom_range(8'h3C, 8'h3F)));
            n = $urandom_range(0, 4);
            for (int k = 0; k < n; k++) begin
               if ($urandom_range(0, 9) == 0) add_str("1234567");
               else repeat ($urandom_range(0, 3))
                  byte_queue.push_back(8'($urandom_range(B_ZERO, B_NINE)));
               if (k + 1 < n) byte_queue.push_back($urandom_range(0, 1) ? B_SEMI : B_COLON);
            end
            repeat ($urandom_range(0, 3))
               byte_queue.push_back(8'($urandom_range(8'h20, 8'h2F)));
            byte_queue.push_back(8'($urandom_range(B_FINLO, B_FINHI)));
         end
         3, 4: begin
            add_str("\033]");
            n = $urandom_range(0, 6);
            repeat (n) byte_queue.push_back(8'($urandom_range(8'h20, 8'hFF)));
            byte_queue.push_back($urandom_range(0, 1) ? B_BEL : B_ESC);
         end
         5: begin
            byte_queue.push_back(B_ESC);
            repeat ($urandom_range(0, 3))
               byte_queue.push_back(8'($urandom_range(8'h20, 8'h2F)));
            byte_queue.push_back(8'($urandom_range(B_ZERO, B_FINHI)));
         end
         6, 7: begin
            n = $urandom_range(1, 3);
            byte_queue.push_back(n == 1 ? 8'(8'hC0 | $urandom_range(0, 31)) :
                                 n == 2 ? 8'(8'hE0 | $urandom_range(0, 15)) :
                                          8'(8'hF0 | $urandom_range(0, 7)));
            repeat (n) byte_queue.push_back(8'(8'h80 | $urandom_range(0, 63)));
         end
         default: repeat ($urandom_range(1, 4))
            byte_queue.push_back(8'($urandom_range(0, 255)));
      endcase
   endtask

   // receiver: random stalls, none when quiet, or a long hold-off on request
   always @(negedge clock) begin
      if (hold_off > 0) begin
         rsp_stall <= 1;
         hold_off <= hold_off - 1;
      end else if (quiet_rx)
         rsp_stall <= 0;
      else
         rsp_stall <= gap_len() != 0 && $urandom_range(0, 1);
   end

   // sample results at the rising edge
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_event('{rsp_event_kind, rsp_code, rsp_private_flag, rsp_inter_count,
                          rsp_inter_first, rsp_inter_second, rsp_item_count,
                          rsp_item_index, rsp_item_value, rsp_last});
   end

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      // directed: controls, UTF-8 cases, escape and CSI forms, overflows
      byte_queue = '{8'h00, 8'h1F, 8'h7F, 8'h41, 8'hC3, 8'hA9, 8'hF4, 8'h8F, 8'hBF,
                     8'hBF, 8'hFF, 8'hE2, 8'h41, 8'hE2, 8'h0A, 8'h82, 8'hAC};
      send_all();
      add_str("\033[m\033[?1;25h\033[12 !\"q\033[1234567m\033[1\n;2H");
      add_str("\033(0\033 \x80\033[<\033]\x18\033[5\x1Aq\033[1=x\033[9@");
      add_str("\033]\007\033]ab\xff\033\\");
      send_all();
      wait_drained();
      // long receiver hold-off while the sender keeps offering bytes
      hold_off <= 200;
      add_str("\033]");
      repeat (6) byte_queue.push_back(8'($urandom_range(8'h20, 8'h7E)));
      add_str("\007hello\033[3;4;5H");
      send_all();
      wait_drained();
      repeat (2) begin
         add_random_sequence();
         if ($urandom_range(0, 30) == 0) begin
            send_all();
            wait_drained();
            quiet_rx = 1'($urandom_range(0, 1));
         end
      end
      send_all();
      wait_drained();
      repeat (20) @(posedge clock);
      if (sb.errors == 0 && sb.pending.size() == 0)
         $display("vt_escape_sequence_parser_tb: clean");
      else
         $display("vt_escape_sequence_parser_tb: errors");
      $finish;
   end

   // watchdog
   initial begin
      #5ms;
      $display("vt_escape_sequence_parser_tb: errors");
      $finish;
   end

endmodule
